@@ sv/ovl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // operation codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;   // shift toward the tail, head takes the new value
      logic remove;   // cells at or after the first match take the right neighbour
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ sv/ovl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ovl_cell (
   input  wire                      clock,
   input  wire ovl_pkg::cell_ctrl_type ctrl,
   input  wire logic signed [31:0]  cmp_value,
   input  wire logic signed [31:0]  left_value,
   input  wire logic signed [31:0]  right_value,
   input  wire logic                cell_valid,
   input  wire logic                seen_in,
   output logic signed [31:0]       entry,
   output logic                     seen_out,
   output logic                     hit
);
   import ovl_pkg::*;

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   assign hit      = cell_valid && (entry_ff == cmp_value);
   assign seen_out = seen_in || hit;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         entry_in = left_value;
      end else if (ctrl.remove && seen_out) begin
         entry_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

@@ sv/ovl_encode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ovl_encode (
   input  wire logic [ovl_pkg::CAPACITY-1:0] first_hit,
   output logic [ovl_pkg::IDX_W-1:0]         index
);
   import ovl_pkg::*;

   // one-hot to binary, or of the indices of set bits
   always_comb begin
      index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_hit[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/ordered_value_list.sv @@
// a transfer accepted into busy_ff executes, and its result strobe then comes from the result register
// a new transfer is accepted only while busy is low, so none is taken during the execute cycle of the cell row
// busy is high for the single execute cycle; results cannot be stalled by the receiver
// reset (synchronous, active high) empties the list and clears busy and the strobe
// stored values are not cleared: a cell only counts while its position is below the count
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_item_value,
   output logic                    rsp_strobe,
   output logic                    rsp_found,
   output logic [3:0]              rsp_match_position,
   output logic [4:0]              rsp_entry_count,
   output logic                    rsp_status
);
   import ovl_pkg::*;

   // captured request
   logic                busy_ff;
   logic [1:0]          func_ff;
   logic signed [31:0]  value_ff;

   // list occupancy
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   // result register
   logic                rsp_strobe_ff;
   logic                rsp_found_ff;
   logic [3:0]          rsp_pos_ff;
   logic [4:0]          rsp_count_ff;
   logic                rsp_status_ff;

   // cell row wiring
   cell_ctrl_type       ctrl;
   logic signed [31:0]  entry  [CAPACITY];
   logic                seen   [CAPACITY+1];
   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] first_hit;
   logic [IDX_W-1:0]    hit_index;

   logic                full;
   logic                is_insert;
   logic                is_lookup;
   logic                found;
   logic [31:0]         pos_wide;
   logic [31:0]         count_wide;

   assign busy       = busy_ff;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign is_insert  = (func_ff == FUNC_INSERT);
   assign is_lookup  = (func_ff == FUNC_REMOVE) || (func_ff == FUNC_QUERY);

   // commands only act in the execute cycle
   assign ctrl = '{insert: busy_ff && is_insert && !full,
                   remove: busy_ff && (func_ff == FUNC_REMOVE)};

   // the chain: head takes the request value, tail holds its own entry on a remove
   assign seen[0] = 1'b0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;

      if (g == 0) begin : g_head
         assign left_value = value_ff;
      end else begin : g_body
         assign left_value = entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_value = entry[g];
      end else begin : g_inner
         assign right_value = entry[g+1];
      end

      ovl_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cmp_value   (value_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .cell_valid  (count_ff > CNT_W'(g)),
         .seen_in     (seen[g]),
         .entry       (entry[g]),
         .seen_out    (seen[g+1]),
         .hit         (hit[g])
      );

      // first match: hit here and no hit nearer the head
      assign first_hit[g] = hit[g] && !seen[g];
   end

   ovl_encode u_encode (
      .first_hit (first_hit),
      .index     (hit_index)
   );

   assign found = is_lookup && seen[CAPACITY];

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove && found) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // outputs wrap to the port widths
   assign pos_wide   = found ? 32'(hit_index) : 32'd0;
   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= busy_ff;
         if (busy_ff) begin
            busy_ff  <= 1'b0;
            count_ff <= count_in;
         end else if (start) begin
            busy_ff <= 1'b1;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         func_ff  <= req_func;
         value_ff <= req_item_value;
      end
      if (busy_ff) begin
         rsp_found_ff  <= found;
         rsp_pos_ff    <= pos_wide[3:0];
         rsp_count_ff  <= count_wide[4:0];
         rsp_status_ff <= is_insert && full;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_status         = rsp_status_ff;

   // a result only follows an execute cycle
   a_strobe_after_exec : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy_ff))
      else $error("result strobe without execute cycle");

   // an accepted transfer always executes in the next cycle
   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted transfer did not execute");

   // occupancy never exceeds the row
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // at most one first match
   a_first_hit : assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_hit))
      else $error("more than one first match");

   // a dropped insert leaves a full list unchanged
   a_drop_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("insert dropped while list not full");

endmodule

`default_nettype wire
